// File: src/msscap_pkg.sv
// Shared types and constants for the masked signature scan with capture.
package msscap_pkg;

	localparam int NUM_POS         = 16;
	localparam int BYTE_W          = 8;
	localparam int OUT_W           = 32;
	localparam int CFG_DATA_W      = 64;
	localparam int MASK_W          = 16;
	localparam int LEN_W           = 5;
	localparam int CFG_IDX_W       = 3;
	localparam int DEF_MAX_PATTERN = 16;
	localparam int DEF_OFFSET_BITS = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_COMPARE_MASK   = 3'd2,
		REG_CAPTURE_MASK   = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} cfg_index_t;

	typedef enum logic {
		KIND_CAPTURE = 1'b0,
		KIND_DONE    = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pattern_low;
		logic [CFG_DATA_W-1:0] pattern_high;
		logic [MASK_W-1:0]     compare_mask;
		logic [MASK_W-1:0]     capture_mask;
		logic [LEN_W-1:0]      pattern_length;
	} cfg_t;

	typedef struct packed {
		logic region_start;
		logic region_end;
	} ctrl_t;

	typedef struct packed {
		logic [NUM_POS-1:0]             pend;
		logic [NUM_POS-1:0][BYTE_W-1:0] bytes;
		logic [OUT_W-1:0]               offset;
		logic                           region_start;
		logic                           region_end;
	} item_t;

endpackage

// File: src/msscap_if.sv
// Request channels: scanned bytes in, capture and done results out.
interface msscap_in_if import msscap_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              region_start;
	logic              region_end;

	modport source(output valid, data_byte, region_start, region_end, input ready);
	modport sink(input valid, data_byte, region_start, region_end, output ready);
endinterface

interface msscap_out_if import msscap_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [BYTE_W-1:0] captured_value;
	logic [OUT_W-1:0]  window_offset;
	logic [OUT_W-1:0]  capture_total;
	logic              last_of_run;

	modport source(output valid, result_kind, captured_value, window_offset, capture_total,
		last_of_run, input ready);
	modport sink(input valid, result_kind, captured_value, window_offset, capture_total,
		last_of_run, output ready);
endinterface

// File: src/masked_signature_scan_capture.sv
// Results of a byte pass through the window registers, the result stage and the output register.
// Throughput: one byte per cycle while the result stage is free; a byte with k results
// holds the result stage until all k are emitted, one result per cycle while scan_out is ready.
// Reset: arst_n clears the window, counts and pipeline valids, and loads the registers
// with their reset values (pattern_length 1, everything else zero).
module masked_signature_scan_capture import msscap_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	msscap_in_if.sink             scan_in,
	msscap_out_if.source          scan_out
);

	cfg_t                   cfg;
	logic                   adv;
	logic                   s1_valid;
	logic [BYTE_W-1:0]      win [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] seen;
	ctrl_t                  ctrl;
	item_t                  item;

	msscap_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msscap_window #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan_in (scan_in),
		.adv     (adv),
		.valid   (s1_valid),
		.win     (win),
		.seen    (seen),
		.ctrl    (ctrl)
	);

	msscap_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_match (
		.cfg  (cfg),
		.win  (win),
		.seen (seen),
		.ctrl (ctrl),
		.item (item)
	);

	msscap_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s1_valid),
		.item     (item),
		.adv      (adv),
		.scan_out (scan_out)
	);

endmodule

// File: src/msscap_cfg.sv
// Configuration register file with a plain write port.
module msscap_cfg import msscap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.compare_mask   <= '0;
			cfg_q.capture_mask   <= '0;
			cfg_q.pattern_length <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg_data;
				REG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg_data;
				REG_COMPARE_MASK:   cfg_q.compare_mask   <= cfg_data[MASK_W-1:0];
				REG_CAPTURE_MASK:   cfg_q.capture_mask   <= cfg_data[MASK_W-1:0];
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/msscap_window.sv
// Input stage: sliding byte window and region byte count.
module msscap_window import msscap_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	msscap_in_if.sink              scan_in,
	input  logic                   adv,
	output logic                   valid,
	output logic [BYTE_W-1:0]      win [MAX_PATTERN],
	output logic [OFFSET_BITS-1:0] seen,
	output ctrl_t                  ctrl
);

	logic [BYTE_W-1:0]      win_q [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] seen_q;
	logic [OFFSET_BITS-1:0] seen_base;
	logic                   clr_q;
	logic                   valid_s1;
	ctrl_t                  ctrl_s1;
	logic                   acc;
	logic                   fresh;

	assign scan_in.ready = !valid_s1 || adv;
	assign acc           = scan_in.valid && scan_in.ready;
	// a new region begins on region_start or with the byte after a region_end byte
	assign fresh         = scan_in.region_start || clr_q;
	assign seen_base     = fresh ? '0 : seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= '0;
			end
			seen_q   <= '0;
			clr_q    <= 1'b0;
			valid_s1 <= 1'b0;
			ctrl_s1  <= '0;
		end else if (acc) begin
			for (int k = 0; k < MAX_PATTERN - 1; k++) begin
				win_q[k] <= fresh ? '0 : win_q[k+1];
			end
			win_q[MAX_PATTERN-1] <= scan_in.data_byte;
			seen_q   <= (&seen_base) ? seen_base : seen_base + OFFSET_BITS'(1);
			clr_q    <= scan_in.region_end;
			valid_s1 <= 1'b1;
			ctrl_s1  <= '{region_start: scan_in.region_start, region_end: scan_in.region_end};
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	assign valid = valid_s1;
	assign win   = win_q;
	assign seen  = seen_q;
	assign ctrl  = ctrl_s1;

endmodule

// File: src/msscap_match.sv
// Window check: aligns the pattern to the newest bytes, compares, picks captures.
module msscap_match import msscap_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
	input  cfg_t                   cfg,
	input  logic [BYTE_W-1:0]      win [MAX_PATTERN],
	input  logic [OFFSET_BITS-1:0] seen,
	input  ctrl_t                  ctrl,
	output item_t                  item
);

	localparam int SUM_W = $clog2(MAX_PATTERN + NUM_POS + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [SUM_W-1:0]          len_raw;
	logic [SUM_W-1:0]          len_eff;
	logic [IDX_W-1:0]          idx [NUM_POS];
	logic [BYTE_W-1:0]         wb [NUM_POS];
	logic [NUM_POS*BYTE_W-1:0] pat_all;
	logic [NUM_POS-1:0]        in_use;
	logic [NUM_POS-1:0]        miss;
	logic [OFFSET_BITS-1:0]    len_ext;
	logic [OFFSET_BITS-1:0]    off_full;
	logic                      match;

	assign pat_all = {cfg.pattern_high, cfg.pattern_low};

	always_comb begin
		len_raw = SUM_W'(cfg.pattern_length);
		len_eff = (len_raw == '0) ? SUM_W'(1) : len_raw;
		if (len_eff > SUM_W'(MAX_PATTERN)) begin
			len_eff = SUM_W'(MAX_PATTERN);
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_POS; i++) begin
			in_use[i] = SUM_W'(i) < len_eff;
			idx[i]    = IDX_W'(SUM_W'(MAX_PATTERN) - len_eff + SUM_W'(i));
			wb[i]     = in_use[i] ? win[idx[i]] : '0;
			// capture positions are never compared
			miss[i]   = in_use[i] && cfg.compare_mask[i] && !cfg.capture_mask[i] &&
				(wb[i] != pat_all[BYTE_W*i +: BYTE_W]);
		end
	end

	assign len_ext  = OFFSET_BITS'(len_eff);
	assign match    = (seen >= len_ext) && !(|miss);
	assign off_full = seen - len_ext;

	always_comb begin
		item.pend         = in_use & cfg.capture_mask & {NUM_POS{match}};
		item.offset       = OUT_W'(off_full);
		item.region_start = ctrl.region_start;
		item.region_end   = ctrl.region_end;
		for (int i = 0; i < NUM_POS; i++) begin
			item.bytes[i] = wb[i];
		end
	end

endmodule

// File: src/msscap_emit.sv
// Result stage: walks the capture positions of a match and drives the output register.
module msscap_emit import msscap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  item_t       item,
	output logic        adv,
	msscap_out_if.source scan_out
);

	logic              valid_s2;
	item_t             item_s2;
	logic [OUT_W-1:0]  cnt_q;
	logic [OUT_W-1:0]  cnt_inc;
	logic              out_valid_q;
	result_kind_t      kind_q;
	logic [BYTE_W-1:0] value_q;
	logic [OUT_W-1:0]  offset_q;
	logic [OUT_W-1:0]  total_q;
	logic              last_q;

	logic [NUM_POS-1:0] lowbit;
	logic [NUM_POS-1:0] rest;
	logic [BYTE_W-1:0]  sel_byte;
	logic               has_cap;
	logic               has_res;
	logic               out_free;
	logic               emit;
	logic               cap_last;
	logic               final_emit;
	logic               retire;

	assign has_cap  = |item_s2.pend;
	assign has_res  = has_cap || item_s2.region_end;
	assign out_free = !out_valid_q || scan_out.ready;
	assign emit     = valid_s2 && has_res && out_free;
	// lowest pending capture position goes first
	assign lowbit   = item_s2.pend & (~item_s2.pend + NUM_POS'(1));
	assign rest     = item_s2.pend & ~lowbit;
	assign cap_last = (rest == '0) && !item_s2.region_end;

	assign final_emit = emit && (has_cap ? cap_last : 1'b1);
	assign retire     = valid_s2 && (!has_res || final_emit);
	assign adv        = in_valid && (!valid_s2 || retire);
	assign cnt_inc    = (&cnt_q) ? cnt_q : cnt_q + OUT_W'(1);

	always_comb begin
		sel_byte = '0;
		for (int i = 0; i < NUM_POS; i++) begin
			if (lowbit[i]) begin
				sel_byte = sel_byte | item_s2.bytes[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (retire) begin
				valid_s2 <= 1'b0;
			end

			// a region start wins over the last update of the previous item
			if (adv && item.region_start) begin
				cnt_q <= '0;
			end else if (emit && has_cap) begin
				cnt_q <= cnt_inc;
			end else if (emit) begin
				cnt_q <= '0;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (scan_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item;
		end else if (emit && has_cap) begin
			item_s2.pend <= rest;
		end

		if (emit) begin
			if (has_cap) begin
				kind_q   <= KIND_CAPTURE;
				value_q  <= sel_byte;
				offset_q <= item_s2.offset;
				total_q  <= cnt_inc;
				last_q   <= cap_last;
			end else begin
				kind_q   <= KIND_DONE;
				value_q  <= '0;
				offset_q <= '0;
				total_q  <= cnt_q;
				last_q   <= 1'b1;
			end
		end
	end

	assign scan_out.valid          = out_valid_q;
	assign scan_out.result_kind    = kind_q;
	assign scan_out.captured_value = value_q;
	assign scan_out.window_offset  = offset_q;
	assign scan_out.capture_total  = total_q;
	assign scan_out.last_of_run    = last_q;

endmodule

// File: src/msscap_checker.sv
// Port-level checks on the result channel, bound to the top level.
module msscap_checker import msscap_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              out_kind,
	input logic [BYTE_W-1:0] out_value,
	input logic [OUT_W-1:0]  out_offset,
	input logic [OUT_W-1:0]  out_total,
	input logic              out_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value) &&
			$stable(out_offset) && $stable(out_total) && $stable(out_last))
		else $error("result changed while stalled");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_DONE) |-> (out_value == '0) && (out_offset == '0))
		else $error("done result carries capture fields");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> (out_kind == KIND_CAPTURE))
		else $error("done result not marked last");

	a_cap_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_CAPTURE) |-> (out_total != '0))
		else $error("capture result with zero total");

endmodule

bind masked_signature_scan_capture msscap_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (scan_out.valid),
	.out_ready  (scan_out.ready),
	.out_kind   (scan_out.result_kind),
	.out_value  (scan_out.captured_value),
	.out_offset (scan_out.window_offset),
	.out_total  (scan_out.capture_total),
	.out_last   (scan_out.last_of_run)
);
